[sv/crsc_pkg.sv]
// ----------------------------------------------------------------------------
// crsc_pkg: shared constants for the clock replacement sector cache
// Port widths fixed by the request and result formats, access kinds and
// controller state codes.
// ----------------------------------------------------------------------------
package crsc_pkg;

    // Width of sector numbers on the ports
    localparam int unsigned SECTOR_PORT_W = 32;
    // Width of the slot number reported on the result port
    localparam int unsigned SLOT_PORT_W   = 6;

    // Access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Controller state
    typedef logic [1:0] state_t;

    localparam state_t ST_IDLE   = 2'd0;
    localparam state_t ST_LOOKUP = 2'd1;
    localparam state_t ST_SCAN   = 2'd2;
    localparam state_t ST_VICTIM = 2'd3;

endpackage

[sv/clock_replacement_sector_cache.sv]
// ----------------------------------------------------------------------------
// clock_replacement_sector_cache: tag and clock replacement engine
// Looks up a sector in a tag memory, picks a second-chance victim on a miss
// and reports the slot and any dirty write-back.
// ----------------------------------------------------------------------------
// Usage:
//   Drive func and sector_number and pulse start while busy is low; the item
//   is taken at that edge and busy rises in the next cycle. One result comes
//   back per item: done is high for exactly one cycle with hit, slot_index,
//   writeback_needed and writeback_sector. The receiver cannot hold it off.
// Timing:
//   Each slot's tag, reference bit and dirty bit share one word of a
//   synchronous memory, read one slot per cycle, lowest slot first. A hit
//   ends the lookup at the matching slot. A miss walks all CACHE_SLOTS tags,
//   then the clock hand moves one slot per cycle over occupied, referenced
//   slots, then the VICTIM state reads the victim word and installs the new
//   one. busy drops in the cycle done is shown, so the next item may start
//   right then.
// Reset:
//   rst_n clears the valid bits, the hand and the controller. The slot memory
//   is not cleared; tag, reference and dirty bits count only in valid slots.
// ----------------------------------------------------------------------------
module clock_replacement_sector_cache #(
    parameter int unsigned CACHE_SLOTS = 64,
    parameter int unsigned SECTOR_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   func,
    input  logic [crsc_pkg::SECTOR_PORT_W-1:0]     sector_number,
    output logic                                   done,
    output logic                                   hit,
    output logic [crsc_pkg::SLOT_PORT_W-1:0]       slot_index,
    output logic                                   writeback_needed,
    output logic [crsc_pkg::SECTOR_PORT_W-1:0]     writeback_sector
);

    localparam int unsigned SLOT_W = $clog2(CACHE_SLOTS);
    localparam int unsigned TAG_W  = (SECTOR_BITS < crsc_pkg::SECTOR_PORT_W) ?
                                     SECTOR_BITS : crsc_pkg::SECTOR_PORT_W;
    // memory word: dirty, reference, tag
    localparam int unsigned WORD_W = TAG_W + 2;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_SLOTS - 1);

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    crsc_pkg::state_t state_reg, state_next;
    logic [SLOT_W-1:0]      ptr_reg, ptr_next;
    logic [SLOT_W-1:0]      hand_reg, hand_next;
    logic                   func_reg, func_next;
    logic [TAG_W-1:0]       tag_reg, tag_next;
    logic [CACHE_SLOTS-1:0] valid_reg, valid_next;

    logic                                done_reg, done_next;
    logic                                hit_reg, hit_next;
    logic [SLOT_W-1:0]                   slot_reg, slot_next;
    logic                                wb_reg, wb_next;
    logic [crsc_pkg::SECTOR_PORT_W-1:0]  wb_sector_reg, wb_sector_next;

    logic [WORD_W-1:0] slot_mem [CACHE_SLOTS];
    logic [WORD_W-1:0] rd_data_reg;
    logic [WORD_W-1:0] wr_data;
    logic              mem_we;
    logic [TAG_W-1:0]  rd_tag;
    logic              rd_ref;
    logic              rd_dirty;
    logic              victim_wb;

    // Slot memory: read data is for the address chosen in the previous cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[ptr_reg] <= wr_data;
        end
        rd_data_reg <= slot_mem[ptr_next];
    end

    assign rd_tag    = rd_data_reg[TAG_W-1:0];
    assign rd_ref    = rd_data_reg[TAG_W];
    assign rd_dirty  = rd_data_reg[TAG_W+1];
    assign victim_wb = valid_reg[ptr_reg] & rd_dirty;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        hand_next      = hand_reg;
        func_next      = func_reg;
        tag_next       = tag_reg;
        valid_next     = valid_reg;
        done_next      = 1'b0;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        wb_next        = wb_reg;
        wb_sector_next = wb_sector_reg;
        mem_we         = 1'b0;
        wr_data        = rd_data_reg;

        unique case (state_reg)
            crsc_pkg::ST_IDLE:
            begin
                ptr_next = '0;
                if (start)
                begin
                    func_next  = func;
                    tag_next   = sector_number[TAG_W-1:0];
                    state_next = crsc_pkg::ST_LOOKUP;
                end
            end

            crsc_pkg::ST_LOOKUP:
            begin
                if (valid_reg[ptr_reg] && (rd_tag == tag_reg))
                begin
                    // set the reference bit, and the dirty bit on a write
                    mem_we         = 1'b1;
                    wr_data        = {rd_dirty | (func_reg == crsc_pkg::FUNC_WRITE),
                                      1'b1, rd_tag};
                    done_next      = 1'b1;
                    hit_next       = 1'b1;
                    slot_next      = ptr_reg;
                    wb_next        = 1'b0;
                    wb_sector_next = '0;
                    state_next     = crsc_pkg::ST_IDLE;
                end
                else if (ptr_reg == LAST_SLOT)
                begin
                    // miss: start the sweep at the slot after the hand
                    ptr_next   = next_slot(hand_reg);
                    state_next = crsc_pkg::ST_SCAN;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            crsc_pkg::ST_SCAN:
            begin
                if (valid_reg[ptr_reg] && rd_ref)
                begin
                    // second chance: drop the reference and move on
                    mem_we   = 1'b1;
                    wr_data  = {rd_dirty, 1'b0, rd_tag};
                    ptr_next = next_slot(ptr_reg);
                end
                else
                begin
                    // hold the pointer so the victim word is read
                    state_next = crsc_pkg::ST_VICTIM;
                end
            end

            crsc_pkg::ST_VICTIM:
            begin
                mem_we              = 1'b1;
                wr_data             = {func_reg == crsc_pkg::FUNC_WRITE, 1'b1, tag_reg};
                valid_next[ptr_reg] = 1'b1;
                hand_next           = ptr_reg;
                done_next           = 1'b1;
                hit_next            = 1'b0;
                slot_next           = ptr_reg;
                wb_next             = victim_wb;
                wb_sector_next      = victim_wb ?
                                      crsc_pkg::SECTOR_PORT_W'(rd_tag) : '0;
                ptr_next            = '0;
                state_next          = crsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crsc_pkg::ST_IDLE;
            ptr_reg   <= '0;
            hand_reg  <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            hand_reg  <= hand_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        tag_reg       <= tag_next;
        hit_reg       <= hit_next;
        slot_reg      <= slot_next;
        wb_reg        <= wb_next;
        wb_sector_reg <= wb_sector_next;
    end

    assign busy             = (state_reg != crsc_pkg::ST_IDLE);
    assign done             = done_reg;
    assign hit              = hit_reg;
    assign slot_index       = crsc_pkg::SLOT_PORT_W'(slot_reg);
    assign writeback_needed = wb_reg;
    assign writeback_sector = wb_sector_reg;

endmodule
